### rtl/wre_pkg.sv
package wre_pkg;

    // One input beat: a stream byte or an end-of-stream marker
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last_content;
    } t_out_beat;

    // Result of the parse core for one processed beat
    typedef struct packed {
        logic      valid;
        t_out_beat beat;
    } t_core_res;

    // Input commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_KEY_BYTE      = 3'd0;
    localparam logic [2:0] KIND_KEY_DONE      = 3'd1;
    localparam logic [2:0] KIND_KEY_DISCARD   = 3'd2;
    localparam logic [2:0] KIND_CONTENT_BYTE  = 3'd3;
    localparam logic [2:0] KIND_EMPTY_CONTENT = 3'd4;
    localparam logic [2:0] KIND_END_OF_STREAM = 3'd5;

    // Header names and special characters
    localparam int ID_LEN = 12;
    localparam int CL_LEN = 14;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Expected character of the record-id name
    function automatic logic [7:0] id_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "W";
            4'd1:    c = "A";
            4'd2:    c = "R";
            4'd3:    c = "C";
            4'd4:    c = "-";
            4'd5:    c = "T";
            4'd6:    c = "R";
            4'd7:    c = "E";
            4'd8:    c = "C";
            4'd9:    c = "-";
            4'd10:   c = "I";
            4'd11:   c = "D";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected character of the length name
    function automatic logic [7:0] cl_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

### rtl/wre_parse_core.sv
module wre_parse_core #(
    parameter int LINE_LIMIT  = 1024,
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wre_pkg::t_in_beat i_beat,
    output wre_pkg::t_core_res o_res
);

    localparam int CW = $clog2(LINE_LIMIT);
    localparam int LB = LENGTH_BITS;
    localparam logic [CW-1:0] COL_LAST = CW'(LINE_LIMIT - 1);
    localparam logic [CW-1:0] COL_ID   = CW'(wre_pkg::ID_LEN);
    localparam logic [CW-1:0] COL_CL   = CW'(wre_pkg::CL_LEN);
    localparam logic [LB-1:0] LEN_MAX  = {LB{1'b1}};

    typedef enum logic [2:0] {
        PH_SEEK_ID  = 3'd0,
        PH_KEY      = 3'd1,
        PH_SEEK_LEN = 3'd2,
        PH_LEN      = 3'd3,
        PH_CONTENT  = 3'd4
    } t_phase;

    t_phase          r_phase,     n_phase;
    logic [CW-1:0]   r_column,    n_column;
    logic            r_prefix,    n_prefix;
    logic            r_drain,     n_drain;
    logic            r_skip,      n_skip;
    logic [LB-1:0]   r_len_val,   n_len_val;
    logic [LB-1:0]   r_remain,    n_remain;
    logic            r_len_neg,   n_len_neg;
    logic            r_len_stop,  n_len_stop;

    logic [7:0]      b;
    t_phase          eff_phase;
    logic            eff_newline;
    logic            is_seek_len;
    logic [CW-1:0]   name_len;
    logic [7:0]      name_ch;
    logic [LB+3:0]   val_ext;
    logic [LB+3:0]   val_x10;
    logic            is_digit;
    logic [LB-1:0]   len_final;

    assign b = i_beat.data_byte;

    // Digit accumulate: v*10+d as shift-add, saturate on carry past LB bits
    assign is_digit = (b >= wre_pkg::CH_ZERO) && (b <= wre_pkg::CH_NINE);
    assign val_ext  = (LB+4)'(r_len_val);
    assign val_x10  = (val_ext << 3) + (val_ext << 1) + (LB+4)'(b - wre_pkg::CH_ZERO);

    // Header name selection for the two seek phases
    assign is_seek_len = (eff_phase == PH_SEEK_LEN);
    assign name_len    = is_seek_len ? COL_CL : COL_ID;
    assign name_ch     = is_seek_len ? wre_pkg::cl_char(r_column[3:0])
                                     : wre_pkg::id_char(r_column[3:0]);
    assign len_final   = r_len_neg ? '0 : r_len_val;

    // Phase fixup: finished content or unknown code restarts the id scan
    always_comb begin
        eff_phase   = r_phase;
        eff_newline = 1'b0;
        case (r_phase)
            PH_SEEK_ID, PH_KEY, PH_SEEK_LEN, PH_LEN: eff_phase = r_phase;
            PH_CONTENT: begin
                if (r_remain == '0) begin
                    eff_phase   = PH_SEEK_ID;
                    eff_newline = 1'b1;
                end
            end
            default: begin
                eff_phase   = PH_SEEK_ID;
                eff_newline = 1'b1;
            end
        endcase
    end

    // Next state and result for one beat
    always_comb begin
        n_phase    = eff_phase;
        n_column   = eff_newline ? '0   : r_column;
        n_prefix   = eff_newline ? 1'b1 : r_prefix;
        n_drain    = eff_newline ? 1'b0 : r_drain;
        n_skip     = r_skip;
        n_len_val  = r_len_val;
        n_remain   = r_remain;
        n_len_neg  = r_len_neg;
        n_len_stop = r_len_stop;
        o_res      = '0;

        if (i_beat.cmd == wre_pkg::CMD_EOS) begin
            n_phase    = PH_SEEK_ID;
            n_column   = '0;
            n_prefix   = 1'b1;
            n_drain    = 1'b0;
            n_skip     = 1'b1;
            n_len_val  = '0;
            n_remain   = '0;
            n_len_neg  = 1'b0;
            n_len_stop = 1'b0;
            o_res.valid     = 1'b1;
            o_res.beat.kind = wre_pkg::KIND_END_OF_STREAM;
        end else if (eff_phase == PH_CONTENT) begin
            n_remain = r_remain - LB'(1);
            o_res.valid             = 1'b1;
            o_res.beat.kind         = wre_pkg::KIND_CONTENT_BYTE;
            o_res.beat.out_byte     = b;
            o_res.beat.last_content = (r_remain == LB'(1));
            if (r_remain == LB'(1)) begin
                n_phase  = PH_SEEK_ID;
                n_column = '0;
                n_prefix = 1'b1;
                n_drain  = 1'b0;
            end
        end else if (n_drain) begin
            // long line: swallow up to and including its newline
            if (b == wre_pkg::CH_NEWLINE) begin
                n_column = '0;
                n_prefix = 1'b1;
                n_drain  = 1'b0;
            end
        end else if (b == wre_pkg::CH_NEWLINE) begin
            n_column = '0;
            n_prefix = 1'b1;
            n_drain  = 1'b0;
            if (eff_phase == PH_KEY) begin
                n_phase = PH_SEEK_LEN;
                o_res.valid     = 1'b1;
                o_res.beat.kind = wre_pkg::KIND_KEY_DONE;
            end else if (eff_phase == PH_LEN) begin
                if (len_final == '0) begin
                    n_phase = PH_SEEK_ID;
                    o_res.valid     = 1'b1;
                    o_res.beat.kind = wre_pkg::KIND_EMPTY_CONTENT;
                end else begin
                    n_remain = len_final;
                    n_phase  = PH_CONTENT;
                end
            end
        end else if (n_column >= COL_LAST) begin
            n_drain = 1'b1;
            if (eff_phase == PH_KEY) begin
                n_phase = PH_SEEK_ID;
                o_res.valid     = 1'b1;
                o_res.beat.kind = wre_pkg::KIND_KEY_DISCARD;
            end else if (eff_phase == PH_LEN) begin
                n_phase = PH_SEEK_LEN;
            end
        end else if (eff_phase == PH_SEEK_ID || eff_phase == PH_SEEK_LEN) begin
            // header name compare, then ':' right after it
            if (n_column < name_len) begin
                if (b != name_ch) n_prefix = 1'b0;
            end else if (n_column == name_len && n_prefix && b == wre_pkg::CH_COLON) begin
                n_skip = 1'b1;
                if (is_seek_len) begin
                    n_phase    = PH_LEN;
                    n_len_val  = '0;
                    n_len_neg  = 1'b0;
                    n_len_stop = 1'b0;
                end else begin
                    n_phase = PH_KEY;
                end
            end
            n_column = n_column + CW'(1);
        end else if (eff_phase == PH_KEY) begin
            n_column = n_column + CW'(1);
            if (!(r_skip && wre_pkg::is_blank(b))) begin
                n_skip = 1'b0;
                o_res.valid         = 1'b1;
                o_res.beat.kind     = wre_pkg::KIND_KEY_BYTE;
                o_res.beat.out_byte = b;
            end
        end else begin
            // length value digits
            n_column = n_column + CW'(1);
            if (!r_len_stop) begin
                if (r_skip && wre_pkg::is_blank(b)) begin
                    n_skip = 1'b1;
                end else if (r_skip && b == wre_pkg::CH_PLUS) begin
                    n_skip = 1'b0;
                end else if (r_skip && b == wre_pkg::CH_MINUS) begin
                    n_skip    = 1'b0;
                    n_len_neg = 1'b1;
                end else begin
                    n_skip = 1'b0;
                    if (is_digit) begin
                        if (val_x10[LB+3:LB] != 4'd0) n_len_val = LEN_MAX;
                        else                          n_len_val = val_x10[LB-1:0];
                    end else begin
                        n_len_stop = 1'b1;
                    end
                end
            end
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEEK_ID;
            r_column   <= '0;
            r_prefix   <= 1'b1;
            r_drain    <= 1'b0;
            r_skip     <= 1'b1;
            r_len_val  <= '0;
            r_remain   <= '0;
            r_len_neg  <= 1'b0;
            r_len_stop <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_column   <= n_column;
            r_prefix   <= n_prefix;
            r_drain    <= n_drain;
            r_skip     <= n_skip;
            r_len_val  <= n_len_val;
            r_remain   <= n_remain;
            r_len_neg  <= n_len_neg;
            r_len_stop <= n_len_stop;
        end
    end

endmodule

### rtl/warc_record_extractor.sv
// Archive record extractor: splits an archive byte stream into record keys
// and record content.
// Input channel: one beat per stream byte (cmd 0) or an end-of-stream
// marker (cmd 1), taken when i_in_valid is high and o_in_stall is low.
// Output channel: zero or one result beat per input beat (key byte, key
// done, key discarded, content byte with last flag, empty content, end of
// stream), taken when o_out_valid is high and i_out_stall is low.
// Each input beat is loaded into the input register when taken; its result
// is then loaded into the result register, from which it is presented.
// Throughput: one input beat per cycle while the receiver does not stall;
// the parse step between the input register and the result register is a
// single compare-and-update pass, whose widest path is the LENGTH_BITS+4
// bit multiply-by-ten and add.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the scan for a record-id line.
// When the receiver stalls, the pending result holds in the result
// register; the parser keeps one beat in its input register and o_in_stall
// rises until the result register frees up.
module warc_record_extractor #(
    parameter int LINE_LIMIT  = 1024,
    parameter int LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wre_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wre_pkg::t_out_beat o_out_data
);

    logic               r_in_valid;
    wre_pkg::t_in_beat  r_in_beat;
    logic               r_out_valid;
    wre_pkg::t_out_beat r_out_beat;
    logic               out_free;
    logic               advance;
    wre_pkg::t_core_res core_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_beat <= i_in_data;
        end
    end

    wre_parse_core #(
        .LINE_LIMIT  (LINE_LIMIT),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_beat  (r_in_beat),
        .o_res   (core_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && core_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_res.valid) begin
            r_out_beat <= core_res.beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

endmodule

### bench/warc_record_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the record extractor. It predicts the result
// beats of every accepted input beat and compares them in order.
module warc_record_checker #(
    parameter int LINE_LIMIT  = 1024,
    parameter int LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  wre_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  wre_pkg::t_out_beat i_out_data,
    output int                 o_errors,
    output int                 o_due
);

    typedef enum logic [2:0] {
        SCAN_ID,
        KEY_TEXT,
        SCAN_LEN,
        LEN_TEXT,
        BODY
    } t_rec_phase;

    // Header names, first character in the top byte
    localparam logic [8*wre_pkg::ID_LEN-1:0] ID_NAME  = {"WARC-T", "REC-ID"};
    localparam logic [8*wre_pkg::CL_LEN-1:0] LEN_NAME = "Content-Length";
    localparam logic [63:0]                  LEN_MAX  = (64'd1 << LENGTH_BITS) - 64'd1;

    // Parser copy
    t_rec_phase  phase;
    int          col;
    bit          name_ok;
    bit          draining;
    bit          lead_blank;
    bit          len_neg;
    bit          len_done;
    logic [63:0] len_acc;
    logic [63:0] remain;

    // Results still owed by the block, oldest first
    wre_pkg::t_out_beat due_q[$];
    int                 due_n;
    int                 fails;

    assign o_errors = fails;
    assign o_due    = due_n;

    function automatic logic [7:0] name_byte(input bit want_id, input int idx);
        return want_id ? ID_NAME[8*(wre_pkg::ID_LEN-1-idx) +: 8]
                       : LEN_NAME[8*(wre_pkg::CL_LEN-1-idx) +: 8];
    endfunction

    function automatic bit ws_byte(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void owe(input logic [2:0] k, input logic [7:0] b, input logic l);
        wre_pkg::t_out_beat r;
        r.kind         = k;
        r.out_byte     = b;
        r.last_content = l;
        due_q.push_back(r);
        due_n++;
    endfunction

    function automatic void line_start();
        col      = 0;
        name_ok  = 1'b1;
        draining = 1'b0;
    endfunction

    function automatic void clear_parser();
        phase      = SCAN_ID;
        line_start();
        lead_blank = 1'b1;
        len_acc    = '0;
        remain     = '0;
        len_neg    = 1'b0;
        len_done   = 1'b0;
    endfunction

    // One input beat through the parser; queues the result it causes
    task automatic parse_beat(input wre_pkg::t_in_beat beat);
        logic [7:0]  b;
        logic [63:0] d;
        logic [63:0] len;
        int          nlen;
        b = beat.data_byte;

        if (beat.cmd == wre_pkg::CMD_EOS) begin
            clear_parser();
            owe(wre_pkg::KIND_END_OF_STREAM, 8'h00, 1'b0);
            return;
        end
        if (phase == BODY && remain == 0) begin
            phase = SCAN_ID;
            line_start();
        end

        // content passes through untouched
        if (phase == BODY) begin
            owe(wre_pkg::KIND_CONTENT_BYTE, b, remain == 64'd1);
            remain--;
            if (remain == 0) begin
                phase = SCAN_ID;
                line_start();
            end
            return;
        end

        if (draining) begin
            if (b == wre_pkg::CH_NEWLINE)
                line_start();
            return;
        end

        // end of line closes key or length value
        if (b == wre_pkg::CH_NEWLINE) begin
            line_start();
            if (phase == KEY_TEXT) begin
                phase = SCAN_LEN;
                owe(wre_pkg::KIND_KEY_DONE, 8'h00, 1'b0);
            end else if (phase == LEN_TEXT) begin
                len = len_neg ? 64'd0 : len_acc;
                if (len == 0) begin
                    phase = SCAN_ID;
                    owe(wre_pkg::KIND_EMPTY_CONTENT, 8'h00, 1'b0);
                end else begin
                    remain = len;
                    phase  = BODY;
                end
            end
            return;
        end

        // line too long: drain the rest of it
        if (col >= LINE_LIMIT - 1) begin
            draining = 1'b1;
            if (phase == KEY_TEXT) begin
                phase = SCAN_ID;
                owe(wre_pkg::KIND_KEY_DISCARD, 8'h00, 1'b0);
            end else if (phase == LEN_TEXT) begin
                phase = SCAN_LEN;
            end
            return;
        end

        // header name compare, colon right after it
        if (phase == SCAN_ID || phase == SCAN_LEN) begin
            nlen = (phase == SCAN_ID) ? wre_pkg::ID_LEN : wre_pkg::CL_LEN;
            if (col < nlen) begin
                if (b != name_byte(phase == SCAN_ID, col))
                    name_ok = 1'b0;
            end else if (col == nlen && name_ok && b == wre_pkg::CH_COLON) begin
                lead_blank = 1'b1;
                if (phase == SCAN_ID) begin
                    phase = KEY_TEXT;
                end else begin
                    phase    = LEN_TEXT;
                    len_acc  = '0;
                    len_neg  = 1'b0;
                    len_done = 1'b0;
                end
            end
            col++;
            return;
        end

        col++;
        if (phase == KEY_TEXT) begin
            if (lead_blank && ws_byte(b))
                return;
            lead_blank = 1'b0;
            owe(wre_pkg::KIND_KEY_BYTE, b, 1'b0);
            return;
        end

        // decimal length value
        if (len_done)
            return;
        if (lead_blank) begin
            if (ws_byte(b))
                return;
            lead_blank = 1'b0;
            if (b == wre_pkg::CH_PLUS)
                return;
            if (b == wre_pkg::CH_MINUS) begin
                len_neg = 1'b1;
                return;
            end
        end
        if (b >= wre_pkg::CH_ZERO && b <= wre_pkg::CH_NINE) begin
            d = {56'd0, b - wre_pkg::CH_ZERO};
            if (len_acc > (LEN_MAX - d) / 64'd10)
                len_acc = LEN_MAX;
            else
                len_acc = len_acc * 64'd10 + d;
        end else begin
            len_done = 1'b1;
        end
    endtask

    initial begin
        fails = 0;
        due_n = 0;
        clear_parser();
    end

    // Compare each taken result beat, then predict from each taken input beat
    always @(posedge i_clk) begin : watch
        wre_pkg::t_out_beat want;
        if (!i_rst_n) begin
            clear_parser();
            due_q.delete();
            due_n = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: kind %0d byte %02h last %0b",
                                 i_out_data.kind, i_out_data.out_byte,
                                 i_out_data.last_content);
                end else begin
                    want = due_q.pop_front();
                    due_n--;
                    if (i_out_data.kind !== want.kind
                            || i_out_data.out_byte !== want.out_byte
                            || i_out_data.last_content !== want.last_content) begin
                        fails++;
                        if (fails <= 10)
                            $display({"result mismatch: expected kind %0d byte %02h last %0b,",
                                      " got kind %0d byte %02h last %0b"},
                                     want.kind, want.out_byte, want.last_content,
                                     i_out_data.kind, i_out_data.out_byte,
                                     i_out_data.last_content);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                parse_beat(i_in_data);
        end
    end

endmodule

### bench/tb_warc_record_extractor.sv
`timescale 1ns / 1ps

module tb_warc_record_extractor;

    localparam int LINE_LIMIT   = 1024;
    localparam int LENGTH_BITS  = 32;
    localparam int RANDOM_BEATS = 100;
    localparam int HOLD_CYCLES  = 150;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    wre_pkg::t_in_beat  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    wre_pkg::t_out_beat out_data;
    int                 errors;
    int                 due;

    // Beats waiting for the feeder, and beat counts on both ends of it
    wre_pkg::t_in_beat  beat_q[$];
    int                 queued    = 0;
    int                 taken     = 0;
    bit                 quiet     = 1'b0;
    bit                 hold_req  = 1'b0;
    string              id_tag;

    warc_record_extractor #(
        .LINE_LIMIT (LINE_LIMIT),
        .LENGTH_BITS(LENGTH_BITS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    warc_record_checker #(
        .LINE_LIMIT (LINE_LIMIT),
        .LENGTH_BITS(LENGTH_BITS)
    ) i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_data (out_data),
        .o_errors   (errors),
        .o_due      (due)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Feeder: offers queued beats, holds a beat while stalled, idles in bursts
    initial begin : feeder
        int gap;
        gap = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!(in_valid && in_stall)) begin
                if (in_valid)
                    taken++;
                if (gap > 0) begin
                    gap--;
                    in_valid <= 1'b0;
                end else if (beat_q.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 4) == 0) begin
                    gap = $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end else begin
                    in_valid <= 1'b1;
                    in_data  <= beat_q.pop_front();
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin : receiver
        int burst;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        wre_pkg::t_in_beat x;
        x.cmd       = wre_pkg::CMD_BYTE;
        x.data_byte = b;
        beat_q.push_back(x);
        queued++;
    endtask

    task automatic put_eos();
        wre_pkg::t_in_beat x;
        x.cmd       = wre_pkg::CMD_EOS;
        x.data_byte = $urandom_range(0, 255);
        beat_q.push_back(x);
        queued++;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    // n random bytes, never a newline
    task automatic put_line_bytes(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = $urandom_range(0, 254);
            if (b >= wre_pkg::CH_NEWLINE)
                b++;
            put_byte(b);
        end
    endtask

    task automatic put_any_bytes(input int n);
        repeat (n) put_byte($urandom_range(0, 255));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return wre_pkg::CH_SPACE;
            1:       return wre_pkg::CH_TAB;
            2:       return 8'h0B;
            3:       return 8'h0C;
            default: return wre_pkg::CH_CR;
        endcase
    endfunction

    // Lines that must not start a key or a length
    task automatic put_noise(input bit before_id);
        case ($urandom_range(0, 6))
            0: put_str("WARC-Type: response\n");
            1: begin
                put_str(id_tag.substr(0, wre_pkg::ID_LEN - 1));
                put_str(" :x\n");
            end
            2: begin
                put_str("x");
                put_str(id_tag);
                put_str("y\n");
            end
            3: put_str(before_id ? "Content-Length: 4\n" : "Content-Lengthy: 4\n");
            4: put_str("content-length: 3\n");
            5: put_str("Content-Length 2\n");
            default: begin
                put_line_bytes($urandom_range(0, 16));
                put_byte(wre_pkg::CH_NEWLINE);
            end
        endcase
    endtask

    // Length line in one of several spellings; n is the content it calls for
    task automatic put_len_line(output int n);
        int k;
        k = $urandom_range(1, 12);
        put_str("Content-Length:");
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin put_str($sformatf(" %0d", k)); n = k; end
            4:          begin put_str($sformatf("+%0d", k)); n = k; end
            5:          begin put_str($sformatf("\t %0d\r", k)); n = k; end
            6:          begin put_str($sformatf(" %0d junk 7", k)); n = k; end
            7:          begin put_str($sformatf(" -%0d", k)); n = 0; end
            8:          begin put_str(" none"); n = 0; end
            default:    begin put_str(" 0"); n = 0; end
        endcase
        put_byte(wre_pkg::CH_NEWLINE);
    endtask

    // One record with random content; now and then cut short by end of stream
    task automatic put_record(input int key_n);
        int first;
        int n;
        int cut;
        first = queued;
        repeat ($urandom_range(0, 2)) put_noise(1'b1);
        put_str(id_tag);
        repeat ($urandom_range(0, 2)) put_byte(pick_blank());
        put_line_bytes(key_n);
        put_byte(wre_pkg::CH_NEWLINE);
        repeat ($urandom_range(0, 2)) put_noise(1'b0);
        put_len_line(n);
        put_any_bytes(n);
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, queued - first - 1);
            repeat (cut) begin
                void'(beat_q.pop_back());
                queued--;
            end
            put_eos();
        end else if ($urandom_range(0, 9) == 0) begin
            put_eos();
        end
    endtask

    task automatic flush();
        wait (taken == queued);
        @(posedge clk);
    endtask

    // Sender pause until the block has delivered everything
    task automatic settle();
        flush();
        wait (due == 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        int first;
        int seg;
        id_tag = "WARC-T";
        id_tag = {id_tag, "REC-ID:"};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end of stream straight after reset
        put_eos();
        // leading blanks skipped, later blanks kept, extreme byte values
        put_str({id_tag, " \t"});
        put_byte(8'h00);
        put_byte(8'hFF);
        put_str(" k\r\n");
        put_str("Content-Length: 3\n");
        put_byte(8'h00);
        put_byte(wre_pkg::CH_NEWLINE);
        put_byte(8'hFF);
        // empty key, then zero, negative and digit-less lengths
        put_str({id_tag, "\n", "Content-Length:+0\n"});
        put_str({id_tag, "a\n", "Content-Length: -7\n"});
        put_str({id_tag, "b\n", "Content-Length:  x12\n"});
        // leading zeros with trailing junk
        put_str({id_tag, "c\n", "Content-Length: 00012abc\n"});
        put_any_bytes(12);
        // saturating length, cut off by end of stream
        put_str({id_tag, "f\n", "Content-Length: 99999999999999\n"});
        put_any_bytes(4);
        put_eos();
        // end of stream inside a key and inside a length value
        put_str({id_tag, " gh"});
        put_eos();
        put_str({id_tag, "i\n", "Content-Length: 4"});
        put_eos();
        flush();

        // random records in segments; the first one carries the long hold-off
        first = queued;
        seg   = 0;
        while (queued - first < RANDOM_BEATS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (seg == 0) begin
                // receiver holds off while the feeder keeps offering
                quiet = 1'b1;
                put_record(12);
                hold_req = 1'b1;
            end
            repeat ($urandom_range(1, 3)) put_record($urandom_range(0, 8));
            flush();
            if (seg == 0)
                settle();
            seg++;
        end

        // last part with no idling
        quiet = 1'b1;
        put_record($urandom_range(1, 8));
        settle();
        repeat (8) @(posedge clk);
        if (errors == 0 && due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
